// File: rtl/core/rket_pkg.sv
// Shared types and codes for the keyed entry table.
`timescale 1ns / 1ps

package rket_pkg;

  localparam int KEY_W   = 64;
  localparam int PATH_W  = 64;
  localparam int COUNT_W = 16;
  localparam int TOTAL_W = 24;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_GET    = 2'd1;
  localparam logic [1:0] ACT_PUT    = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_MISMATCH  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOTHING   = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PATH_W-1:0]  path;
    logic               flag;
    logic [COUNT_W-1:0] count;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic done;
    logic match;
    logic free_avail;
  } scan_stat_t;

endpackage

// File: rtl/core/refcounted_keyed_entry_table_core.sv
// Top level of the reference-counted keyed entry table.
//
//   channel   signals                                              direction
//   request   start, busy, action, key, path_tag, hijacker_flag,   in (busy out)
//             initial_count
//   result    done, status, found_path_tag, found_flag,            out
//             found_count, enabled
//
// A request transfers when start is high and busy is low. Requests with a
// zero key, an unused action or a put with nothing held answer in the cycle
// after the transfer. All others walk the slot RAM one entry a cycle through
// its read port, then answer from the scan result.
// Reset empties the table at once through per-entry valid bits.
// done is high for one cycle per result; the receiver cannot stall.
`timescale 1ns / 1ps

module refcounted_keyed_entry_table_core import rket_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [KEY_W-1:0]   key,
  input  logic [PATH_W-1:0]  path_tag,
  input  logic               hijacker_flag,
  input  logic [COUNT_W-1:0] initial_count,
  output logic               done,
  output logic [2:0]         status,
  output logic [PATH_W-1:0]  found_path_tag,
  output logic               found_flag,
  output logic [COUNT_W-1:0] found_count,
  output logic               enabled
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t               state;
  logic [ENTRIES-1:0]   valid;
  logic [TOTAL_W-1:0]   total;

  logic [1:0]           req_action;
  logic [KEY_W-1:0]     req_key;
  logic [PATH_W-1:0]    req_path;
  logic                 req_flag;
  logic [COUNT_W-1:0]   req_init;

  logic                 accept;
  logic                 needs_scan;
  logic [2:0]           imm_status;

  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic [SLOT_W-1:0]    ram_rdata;
  scan_stat_t           scan_stat;
  logic [IW-1:0]        match_idx;
  logic [IW-1:0]        free_idx;
  slot_t                match_slot;
  logic                 decide;

  logic                 we;
  logic [IW-1:0]        waddr;
  slot_t                wslot;
  logic                 set_valid;
  logic                 clr_valid;
  logic [TOTAL_W-1:0]   total_next;
  logic [2:0]           status_next;
  logic                 lookup_hit;
  logic [COUNT_W-1:0]   count_dn;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign decide = (state == S_SCAN) && scan_stat.done;

  always_comb begin
    needs_scan = 1'b0;
    imm_status = ST_NOT_FOUND;
    if (key != '0) begin
      unique case (action)
        ACT_LOOKUP, ACT_GET: needs_scan = 1'b1;
        ACT_PUT: begin
          if (total == '0) begin
            imm_status = ST_NOTHING;
          end else begin
            needs_scan = 1'b1;
          end
        end
        default: needs_scan = 1'b0;
      endcase
    end
  end

  rket_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(ENTRIES),
    .AW   (IW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wslot),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  rket_scan #(
    .ENTRIES(ENTRIES),
    .IW     (IW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .go        (accept && needs_scan),
    .key       (req_key),
    .valid     (valid),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_slot   (slot_t'(ram_rdata)),
    .stat      (scan_stat),
    .match_idx (match_idx),
    .free_idx  (free_idx),
    .match_slot(match_slot)
  );

  assign count_dn = (match_slot.count != '0) ? match_slot.count - 1'b1 : '0;

  always_comb begin
    we          = 1'b0;
    waddr       = match_idx;
    wslot       = '{key: req_key, path: match_slot.path, flag: match_slot.flag,
                    count: match_slot.count};
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    total_next  = total;
    status_next = ST_NOT_FOUND;
    lookup_hit  = 1'b0;
    if (decide) begin
      unique case (req_action)
        ACT_LOOKUP: begin
          if (scan_stat.match) begin
            status_next = ST_OK;
            lookup_hit  = 1'b1;
          end
        end
        ACT_GET: begin
          if (scan_stat.match) begin
            if (match_slot.path != req_path || match_slot.flag != req_flag) begin
              status_next = ST_MISMATCH;
            end else begin
              we          = 1'b1;
              wslot.count = (match_slot.count == COUNT_MAX) ? match_slot.count
                                                            : match_slot.count + 1'b1;
              total_next  = (total == TOTAL_MAX) ? total : total + 1'b1;
              status_next = ST_OK;
            end
          end else if (scan_stat.free_avail) begin
            we          = 1'b1;
            waddr       = free_idx;
            wslot       = '{key: req_key, path: req_path, flag: req_flag,
                            count: req_init};
            set_valid   = 1'b1;
            total_next  = (total == TOTAL_MAX) ? total : total + 1'b1;
            status_next = ST_OK;
          end else begin
            status_next = ST_FULL;
          end
        end
        ACT_PUT: begin
          if (scan_stat.match) begin
            // Drop the valid bit when the count runs out; the slot then reads as free.
            if (count_dn == '0) begin
              clr_valid = 1'b1;
            end else begin
              we          = 1'b1;
              wslot.count = count_dn;
            end
            total_next  = total - 1'b1;
            status_next = ST_OK;
          end
        end
        default: status_next = ST_NOT_FOUND;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      total <= '0;
      done  <= 1'b0;
    end else begin
      done <= (accept && !needs_scan) || decide;
      unique case (state)
        S_IDLE: begin
          if (accept && needs_scan) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (decide) begin
            state <= S_IDLE;
            total <= total_next;
            if (set_valid) begin
              valid[free_idx] <= 1'b1;
            end
            if (clr_valid) begin
              valid[match_idx] <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_key    <= key;
      req_path   <= path_tag;
      req_flag   <= hijacker_flag;
      req_init   <= initial_count;
      if (!needs_scan) begin
        status         <= imm_status;
        found_path_tag <= '0;
        found_flag     <= 1'b0;
        found_count    <= '0;
        enabled        <= (total != '0);
      end
    end
    if (decide) begin
      status         <= status_next;
      found_path_tag <= lookup_hit ? match_slot.path : '0;
      found_flag     <= lookup_hit && match_slot.flag;
      found_count    <= lookup_hit ? match_slot.count : '0;
      enabled        <= (total_next != '0);
    end
  end

`ifndef ASSERT_OFF
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(decide || (accept && !needs_scan)))
    else $error("result strobe without a finished request");

  a_enabled_total: assert property (@(posedge clk) disable iff (rst)
    done |-> (enabled == (total != '0)))
    else $error("enabled disagrees with the total count");

  a_fail_no_change: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> $stable(total))
    else $error("failed request changed the total count");

  a_scan_only_busy: assert property (@(posedge clk) disable iff (rst)
    (rd_en || scan_stat.done) |-> (state == S_SCAN))
    else $error("table read outside a scan");
`endif

endmodule

// File: rtl/core/rket_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module rket_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/rket_scan.sv
// Slot scanner: walks the table once, finding the key and the first free slot.
`timescale 1ns / 1ps

module rket_scan import rket_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [KEY_W-1:0]   key,
  input  logic [ENTRIES-1:0] valid,
  output logic               rd_en,
  output logic [IW-1:0]      rd_addr,
  input  slot_t              rd_slot,
  output scan_stat_t         stat,
  output logic [IW-1:0]      match_idx,
  output logic [IW-1:0]      free_idx,
  output slot_t              match_slot
);

  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  logic            issuing;
  logic [IW-1:0]   issue_idx;
  logic            rd_pend;
  logic [IW-1:0]   rd_idx;
  logic [KEY_W-1:0] eff_key;

  assign rd_en   = issuing;
  assign rd_addr = issue_idx;
  // An entry without its valid bit reads as a free slot.
  assign eff_key = valid[rd_idx] ? rd_slot.key : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      issue_idx <= '0;
      rd_pend   <= 1'b0;
      stat      <= '0;
    end else begin
      rd_pend   <= issuing;
      stat.done <= rd_pend && (rd_idx == LAST);
      if (go) begin
        issuing         <= 1'b1;
        issue_idx       <= '0;
        stat.match      <= 1'b0;
        stat.free_avail <= 1'b0;
      end else begin
        if (issuing) begin
          if (issue_idx == LAST) begin
            issuing <= 1'b0;
          end else begin
            issue_idx <= issue_idx + 1'b1;
          end
        end
        if (rd_pend) begin
          if (!stat.match && eff_key == key) begin
            stat.match <= 1'b1;
          end
          if (!stat.free_avail && eff_key == '0) begin
            stat.free_avail <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= issue_idx;
    if (rd_pend && !stat.match && eff_key == key) begin
      match_idx  <= rd_idx;
      match_slot <= rd_slot;
    end
    if (rd_pend && !stat.free_avail && eff_key == '0) begin
      free_idx <= rd_idx;
    end
  end

endmodule

// File: dv/refcounted_keyed_entry_table_core_tb.sv
// Self-checking testbench for the reference-counted keyed entry table core.
`timescale 1ns / 1ps

module refcounted_keyed_entry_table_core_tb;
  import rket_pkg::*;

  localparam int TBL_ENTRIES = 16;
  localparam int KEY_POOL    = 20;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [KEY_W-1:0]   key;
    logic [PATH_W-1:0]  path;
    logic               flag;
    logic [COUNT_W-1:0] init_count;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [PATH_W-1:0]  path;
    logic               flag;
    logic [COUNT_W-1:0] count;
    logic               enabled;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req_drv = '0;
  logic busy;
  logic done;
  logic [2:0] status;
  logic [PATH_W-1:0] found_path_tag;
  logic found_flag;
  logic [COUNT_W-1:0] found_count;
  logic enabled;

  // Mirror of the table contents
  logic [KEY_W-1:0]   tbl_key   [TBL_ENTRIES];
  logic [PATH_W-1:0]  tbl_path  [TBL_ENTRIES];
  logic               tbl_flag  [TBL_ENTRIES];
  logic [COUNT_W-1:0] tbl_count [TBL_ENTRIES];
  logic [TOTAL_W-1:0] tbl_total;

  // Keys the random traffic keeps coming back to, with their usual tags
  logic [KEY_W-1:0]  known_key  [KEY_POOL];
  logic [PATH_W-1:0] known_path [KEY_POOL];
  logic              known_flag [KEY_POOL];

  req_t    requests_waiting [$];
  int      idle_pct_waiting [$];
  answer_t answers_due [$];
  int      fail_count = 0;

  always #5 clk = ~clk;

  refcounted_keyed_entry_table_core #(.ENTRIES(TBL_ENTRIES)) DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (req_drv.action),
    .key            (req_drv.key),
    .path_tag       (req_drv.path),
    .hijacker_flag  (req_drv.flag),
    .initial_count  (req_drv.init_count),
    .done           (done),
    .status         (status),
    .found_path_tag (found_path_tag),
    .found_flag     (found_flag),
    .found_count    (found_count),
    .enabled        (enabled)
  );

  // Apply one request to the mirrored table and return the answer it earns.
  function automatic answer_t table_step_answer(input req_t r);
    answer_t ans;
    int hit;
    int free_slot;
    int i;
    ans = '0;
    ans.status = ST_NOT_FOUND;
    hit = -1;
    free_slot = -1;
    for (i = 0; i < TBL_ENTRIES; i++) begin
      if (hit < 0 && tbl_key[i] == r.key) hit = i;
      if (free_slot < 0 && tbl_key[i] == '0) free_slot = i;
    end
    if (r.key != '0) begin
      case (r.action)
        ACT_LOOKUP: begin
          if (hit >= 0) begin
            ans.status = ST_OK;
            ans.path   = tbl_path[hit];
            ans.flag   = tbl_flag[hit];
            ans.count  = tbl_count[hit];
          end
        end
        ACT_GET: begin
          if (hit >= 0) begin
            if (tbl_path[hit] != r.path || tbl_flag[hit] != r.flag) begin
              ans.status = ST_MISMATCH;
            end else begin
              if (tbl_count[hit] != COUNT_MAX) tbl_count[hit]++;
              if (tbl_total != TOTAL_MAX) tbl_total++;
              ans.status = ST_OK;
            end
          end else if (free_slot >= 0) begin
            tbl_key[free_slot]   = r.key;
            tbl_path[free_slot]  = r.path;
            tbl_flag[free_slot]  = r.flag;
            tbl_count[free_slot] = r.init_count;
            if (tbl_total != TOTAL_MAX) tbl_total++;
            ans.status = ST_OK;
          end else begin
            ans.status = ST_FULL;
          end
        end
        ACT_PUT: begin
          // Nothing held is judged before the key search
          if (tbl_total == '0) begin
            ans.status = ST_NOTHING;
          end else if (hit >= 0) begin
            if (tbl_count[hit] != '0) tbl_count[hit]--;
            if (tbl_count[hit] == '0) begin
              tbl_key[hit]  = '0;
              tbl_path[hit] = '0;
              tbl_flag[hit] = 1'b0;
            end
            tbl_total--;
            ans.status = ST_OK;
          end
        end
        default: ;
      endcase
    end
    ans.enabled = (tbl_total != '0);
    return ans;
  endfunction

  // Mostly well-formed traffic over the known keys, with some noise mixed in.
  function automatic req_t random_request(input bit get_heavy);
    req_t r;
    int pick;
    int roll;
    pick = $urandom_range(0, KEY_POOL - 1);
    r.key  = known_key[pick];
    r.path = known_path[pick];
    r.flag = known_flag[pick];
    roll = $urandom_range(0, 99);
    if (roll < 3) r.action = ACT_UNUSED;
    else if (roll < 25) r.action = ACT_LOOKUP;
    else if (roll < (get_heavy ? 80 : 50)) r.action = ACT_GET;
    else r.action = ACT_PUT;
    roll = $urandom_range(0, 99);
    if (roll < 4) r.key = '0;
    else if (roll < 9) r.key = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < 8) r.path = {$urandom, $urandom};
    else if (roll < 12) r.flag = ~r.flag;
    roll = $urandom_range(0, 99);
    if (roll < 70) r.init_count = COUNT_W'($urandom_range(0, 3));
    else if (roll < 90) r.init_count = COUNT_W'($urandom);
    else r.init_count = COUNT_MAX - COUNT_W'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic queue_request(input logic [1:0] act, input logic [KEY_W-1:0] k,
                               input logic [PATH_W-1:0] p, input logic f,
                               input logic [COUNT_W-1:0] n);
    requests_waiting.push_back({act, k, p, f, n});
    idle_pct_waiting.push_back(11);
  endtask

  // Present requests; record the expected answer on each transfer.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) answers_due.push_back(table_step_answer(req_drv));
      if (!start || !busy) begin
        if (requests_waiting.size() != 0 &&
            $urandom_range(0, 99) >= idle_pct_waiting[0]) begin
          req_drv <= requests_waiting.pop_front();
          idle_pct_waiting.delete(0);
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check
    answer_t due;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        $error("result with no request outstanding: status %0d", status);
        fail_count++;
      end else begin
        due = answers_due.pop_front();
        if (status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, status);
          fail_count++;
        end
        if (found_path_tag !== due.path) begin
          $error("found_path_tag: expected %h, got %h", due.path, found_path_tag);
          fail_count++;
        end
        if (found_flag !== due.flag) begin
          $error("found_flag: expected %0d, got %0d", due.flag, found_flag);
          fail_count++;
        end
        if (found_count !== due.count) begin
          $error("found_count: expected %0d, got %0d", due.count, found_count);
          fail_count++;
        end
        if (enabled !== due.enabled) begin
          $error("enabled: expected %0d, got %0d", due.enabled, enabled);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int i;
    int n;
    for (i = 0; i < TBL_ENTRIES; i++) begin
      tbl_key[i]   = '0;
      tbl_path[i]  = '0;
      tbl_flag[i]  = 1'b0;
      tbl_count[i] = '0;
    end
    tbl_total = '0;
    for (i = 0; i < KEY_POOL; i++) begin
      known_key[i]  = {$urandom, $urandom};
      if (known_key[i] == '0) known_key[i] = KEY_W'(i + 1);
      known_path[i] = {$urandom, $urandom};
      known_flag[i] = 1'($urandom_range(0, 1));
    end

    // Empty table, zero key and the unused action
    queue_request(ACT_LOOKUP, 64'd1, '0, 1'b0, '0);
    queue_request(ACT_PUT,    64'd1, '0, 1'b0, '0);
    queue_request(ACT_GET,    '0, '1, 1'b1, COUNT_MAX);
    queue_request(ACT_LOOKUP, '0, '0, 1'b0, '0);
    queue_request(ACT_PUT,    '0, '0, 1'b0, '0);
    queue_request(ACT_UNUSED, 64'd5, '1, 1'b1, COUNT_MAX);
    // Full-scale entry: count saturates on the second get
    queue_request(ACT_GET,    '1, '1, 1'b1, COUNT_MAX);
    queue_request(ACT_GET,    '1, '1, 1'b1, '0);
    queue_request(ACT_LOOKUP, '1, '0, 1'b0, '0);
    queue_request(ACT_GET,    '1, '1, 1'b0, '0);
    queue_request(ACT_GET,    '1, {{(PATH_W-1){1'b1}}, 1'b0}, 1'b1, '0);
    // Entry created with a zero count clears on its first put
    queue_request(ACT_GET,    64'h8000_0000_0000_0001, '0, 1'b0, '0);
    queue_request(ACT_LOOKUP, 64'h8000_0000_0000_0001, '0, 1'b0, '0);
    queue_request(ACT_PUT,    64'h8000_0000_0000_0001, '0, 1'b0, '0);
    queue_request(ACT_LOOKUP, 64'h8000_0000_0000_0001, '0, 1'b0, '0);
    queue_request(ACT_PUT,    64'd2, '0, 1'b0, '0);
    // Drain the total to zero, then one put too many
    queue_request(ACT_PUT,    '1, '0, 1'b0, '0);
    queue_request(ACT_PUT,    '1, '0, 1'b0, '0);
    queue_request(ACT_PUT,    '1, '0, 1'b0, '0);
    queue_request(ACT_GET,    64'd3, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1, 16'd1);
    queue_request(ACT_PUT,    64'd3, '0, 1'b0, '0);

    // Alternate get-heavy and put-heavy bursts so the table fills and empties
    for (i = 0; i < 850; i++) begin
      n = (i < 290) ? 11 : (i < 570) ? 45 : 0;
      requests_waiting.push_back(random_request(((i / 40) % 2) == 0));
      idle_pct_waiting.push_back(n);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (requests_waiting.size() != 0 || start) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    // Catch any stray result after the last one
    repeat (2 * TBL_ENTRIES + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
